// File: sv/dtoi_pkg.sv
// shared types, character codes and defaults for the decimal text to integer converter
package dtoi_pkg;

  localparam int unsigned DTOI_RESULT_BITS = 32;
  localparam int unsigned DTOI_QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CC_SPACE,
    CC_SIGN,
    CC_DIGIT,
    CC_OTHER
  } char_class_e;

  typedef enum logic [1:0] {
    PH_SPACES,
    PH_SIGNED,
    PH_DIGITS,
    PH_STOPPED
  } parse_phase_e;

  typedef struct packed {
    char_class_e cls;
    logic        minus;
    logic [3:0]  digit;
    logic        last;
  } char_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic pop;
    logic pop_last;
  } back_stat_t;

endpackage

// File: sv/dtoi_front.sv
// front end: classifies each incoming character request
module dtoi_front import dtoi_pkg::*; (
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output char_item_t item_o
);

  logic [3:0] offset;

  assign offset = text_byte_i[3:0] - CHAR_ZERO[3:0];

  always_comb begin
    item_o       = '0;
    item_o.minus = (text_byte_i == CHAR_MINUS);
    item_o.digit = offset;
    item_o.last  = end_of_text_i;
    priority if (text_byte_i == CHAR_SPACE) begin
      item_o.cls = CC_SPACE;
    end else if (text_byte_i == CHAR_MINUS || text_byte_i == CHAR_PLUS) begin
      item_o.cls = CC_SIGN;
    end else if (text_byte_i >= CHAR_ZERO && text_byte_i <= CHAR_NINE) begin
      item_o.cls = CC_DIGIT;
    end else begin
      item_o.cls = CC_OTHER;
    end
  end

endmodule

// File: sv/dtoi_queue.sv
// two-entry queue of classified characters between front and back
module dtoi_queue import dtoi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  char_item_t  item_i,
  input  logic        pop_i,
  output char_item_t  head_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrBits = $clog2(DTOI_QUEUE_DEPTH);
  localparam int unsigned CntBits = $clog2(DTOI_QUEUE_DEPTH + 1);

  char_item_t         mem_q [DTOI_QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign stat_o.full  = (count_q == CntBits'(DTOI_QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
    next_ptr = (p == PtrBits'(DTOI_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: sv/dtoi_back.sv
// back end: parse state, saturating accumulate and result register
module dtoi_back import dtoi_pkg::*; #(
  parameter int unsigned RESULT_BITS = DTOI_RESULT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  char_item_t             head_i,
  output back_stat_t             stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [RESULT_BITS-1:0] value_o
);

  localparam int unsigned WideBits = RESULT_BITS + 4;

  parse_phase_e           phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic                   fz_q, fz_d;
  logic [RESULT_BITS-1:0] mag_q, mag_d;
  logic                   out_valid_q, out_valid_d;
  logic [RESULT_BITS-1:0] value_q, value_d;

  logic                   out_free;
  logic                   pop;
  logic [RESULT_BITS-1:0] limit;
  logic [WideBits-1:0]    mag_w;
  logic [WideBits-1:0]    cand;
  logic                   ovf;
  parse_phase_e           take_phase;
  logic [RESULT_BITS-1:0] take_mag;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = head_valid_i && (!head_i.last || out_free);

  assign stat_o.pop      = pop;
  assign stat_o.pop_last = pop && head_i.last;

  assign limit = {1'b1, {(RESULT_BITS - 1){1'b0}}} - RESULT_BITS'(!neg_q);
  assign mag_w = WideBits'(mag_q);
  assign cand  = (mag_w << 3) + (mag_w << 1) + WideBits'(head_i.digit);
  assign ovf   = cand > WideBits'(limit);

  assign take_phase = ovf ? PH_STOPPED : PH_DIGITS;
  assign take_mag   = ovf ? limit : cand[RESULT_BITS-1:0];

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    fz_d        = fz_q;
    mag_d       = mag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    if (pop) begin
      unique case (phase_q)
        PH_SPACES: begin
          unique case (head_i.cls)
            CC_SPACE: ;
            CC_SIGN: begin
              neg_d   = head_i.minus;
              phase_d = PH_SIGNED;
            end
            CC_DIGIT: begin
              mag_d   = take_mag;
              phase_d = take_phase;
            end
            default: phase_d = PH_STOPPED;
          endcase
        end
        PH_SIGNED: begin
          unique case (head_i.cls)
            CC_SIGN: begin
              fz_d    = 1'b1;
              phase_d = PH_STOPPED;
            end
            CC_DIGIT: begin
              mag_d   = take_mag;
              phase_d = take_phase;
            end
            default: phase_d = PH_STOPPED;
          endcase
        end
        PH_DIGITS: begin
          if (head_i.cls == CC_DIGIT) begin
            mag_d   = take_mag;
            phase_d = take_phase;
          end else begin
            phase_d = PH_STOPPED;
          end
        end
        default: ;
      endcase
      if (head_i.last) begin
        out_valid_d = 1'b1;
        if (fz_d) begin
          value_d = '0;
        end else if (neg_d) begin
          value_d = '0 - mag_d;
        end else begin
          value_d = mag_d;
        end
        phase_d = PH_SPACES;
        neg_d   = 1'b0;
        fz_d    = 1'b0;
        mag_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACES;
      neg_q       <= 1'b0;
      fz_q        <= 1'b0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      fz_q        <= fz_d;
      mag_q       <= mag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

// File: sv/decimal_text_to_int32_saturating.sv
// top level of the saturating decimal text to signed integer converter
// Takes one ASCII character per request, end_of_text_i marking the last one of a string, and
// returns one saturated two's complement value per string on the output channel. Leading
// spaces are skipped, one optional sign may follow, then decimal digits; a second sign before
// any digit gives 0 and any other character ends the number. Sustained rate is one character
// per cycle while the output register is free; a result is loaded into the output register when
// its last character, after passing through the queue, is popped by the parse state. A two-entry
// queue sits between the classifier and the parse state, so while a finished result waits on the
// output register the input keeps flowing until the next last character reaches the head of the
// queue; the queue then takes one more character before the input stalls.
module decimal_text_to_int32_saturating import dtoi_pkg::*; #(
  parameter int unsigned RESULT_BITS = DTOI_RESULT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    text_byte_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [RESULT_BITS-1:0] parsed_value_o
);

  char_item_t             front_item;
  char_item_t             head_item;
  queue_stat_t            q_stat;
  back_stat_t             b_stat;
  logic [RESULT_BITS-1:0] value;

  assign in_ready_o = !q_stat.full;

  dtoi_front u_front (
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .item_o        (front_item)
  );

  dtoi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .item_i (front_item),
    .pop_i  (b_stat.pop),
    .head_o (head_item),
    .stat_o (q_stat)
  );

  dtoi_back #(
    .RESULT_BITS (RESULT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_stat.empty),
    .head_i       (head_item),
    .stat_o       (b_stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value)
  );

  assign parsed_value_o = $signed(value);

`ifndef SYNTHESIS
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !q_stat.empty)
    else $error("accepted character missing from queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.pop |-> !q_stat.empty)
    else $error("back end popped an empty queue");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.pop_last |=> out_valid_o)
    else $error("last character produced no result");
`endif

endmodule

// File: tb/dtoi_value_checker.sv
`timescale 1ns / 1ps
// checker that predicts the parsed value of each string and compares it with the converter output
module dtoi_value_checker import dtoi_pkg::*; (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [7:0]                         text_byte_i,
  input  logic                               end_of_text_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [DTOI_RESULT_BITS-1:0] parsed_value_i,
  output int                                 error_count_o,
  output int                                 pending_o
);

  parse_phase_e                       phase_q;
  logic                               negative_q;
  logic                               force_zero_q;
  longint unsigned                    magnitude_q;
  logic signed [DTOI_RESULT_BITS-1:0] expected_values[$];
  logic signed [DTOI_RESULT_BITS-1:0] wanted_value;
  int                                 error_count = 0;
  int                                 pending_count = 0;

  assign error_count_o = error_count;
  assign pending_o     = pending_count;

  task automatic report_mismatch(input string msg);
    $display("dtoi check at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic clear_parse();
    phase_q      = PH_SPACES;
    negative_q   = 1'b0;
    force_zero_q = 1'b0;
    magnitude_q  = 0;
  endtask

  task automatic take_digit(input logic [3:0] d);
    longint unsigned limit;
    limit = 64'd1 << (DTOI_RESULT_BITS - 1);
    if (!negative_q) begin
      limit = limit - 1;
    end
    if (magnitude_q > (limit - longint'(d)) / 10) begin
      magnitude_q = limit;
      phase_q     = PH_STOPPED;
    end else begin
      magnitude_q = magnitude_q * 10 + longint'(d);
      phase_q     = PH_DIGITS;
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    logic            is_digit;
    logic            is_sign;
    logic [7:0]      digit;
    logic [63:0]     value;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_sign  = (c == CHAR_MINUS) || (c == CHAR_PLUS);
    digit    = c - CHAR_ZERO;
    case (phase_q)
      PH_SPACES: begin
        if (c == CHAR_SPACE) begin
        end else if (is_sign) begin
          negative_q = (c == CHAR_MINUS);
          phase_q    = PH_SIGNED;
        end else if (is_digit) begin
          take_digit(digit[3:0]);
        end else begin
          phase_q = PH_STOPPED;
        end
      end
      PH_SIGNED: begin
        if (is_sign) begin
          force_zero_q = 1'b1;
          phase_q      = PH_STOPPED;
        end else if (is_digit) begin
          take_digit(digit[3:0]);
        end else begin
          phase_q = PH_STOPPED;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          take_digit(digit[3:0]);
        end else begin
          phase_q = PH_STOPPED;
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      value = '0;
      if (!force_zero_q) begin
        value = negative_q ? 64'd0 - magnitude_q : magnitude_q;
      end
      expected_values.push_back(value[DTOI_RESULT_BITS-1:0]);
      clear_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      expected_values.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("parsed_value %0d with no string pending", parsed_value_i));
        end else begin
          wanted_value = expected_values.pop_front();
          if (parsed_value_i !== wanted_value) begin
            report_mismatch($sformatf("parsed_value %0d, expected %0d",
                                      parsed_value_i, wanted_value));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_char(text_byte_i, end_of_text_i);
      end
    end
    pending_count = expected_values.size();
  end

endmodule

// File: tb/decimal_text_to_int32_saturating_tb.sv
`timescale 1ns / 1ps
// testbench top that drives character strings into the converter and reports the verdict
module decimal_text_to_int32_saturating_tb import dtoi_pkg::*; ();

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic [7:0]                         text_byte_i = 8'h00;
  logic                               end_of_text_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [DTOI_RESULT_BITS-1:0] parsed_value_o;

  int         error_count;
  int         pending_count;
  int         chars_sent = 0;
  logic       no_idle = 1'b0;
  logic [7:0] text_q[$];

  decimal_text_to_int32_saturating #(
    .RESULT_BITS(DTOI_RESULT_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parsed_value_o (parsed_value_o)
  );

  dtoi_value_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parsed_value_i (parsed_value_o),
    .error_count_o  (error_count),
    .pending_o      (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= c;
    end_of_text_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    text_q.delete();
  endtask

  initial begin : result_drain
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int unsigned     kind;
    int unsigned     count;
    longint unsigned num;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed strings
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    append_text(" -+5");
    send_text();
    append_text("+ 3");
    send_text();
    append_text("12-4");
    send_text();
    append_text("9x8");
    send_text();
    append_text("-");
    send_text();
    append_text("4294967296");
    send_text();

    while (chars_sent < 650) begin
      no_idle = ($urandom_range(0, 7) == 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 6) begin
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) append_text(" ");
        case ($urandom_range(0, 2))
          1: append_text("+");
          2: append_text("-");
          default: begin
          end
        endcase
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) append_text("0");
        end
        case ($urandom_range(0, 3))
          0: num = $urandom_range(0, 999);
          1: num = $urandom;
          2: num = 64'd2147483640 + $urandom_range(0, 15);
          default: num = {$urandom, $urandom} % 64'd1000000000000;
        endcase
        append_text($sformatf("%0d", num));
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(8'($urandom_range(0, 255)));
          append_text($sformatf("%0d", $urandom_range(0, 99)));
        end
      end else if (kind == 7) begin
        repeat ($urandom_range(0, 2)) append_text(" ");
        append_text($urandom_range(0, 1) ? "-" : "+");
        case ($urandom_range(0, 2))
          0: append_text("-");
          1: append_text("+");
          default: append_text(" ");
        endcase
        append_text($sformatf("%0d", $urandom_range(0, 99)));
      end else begin
        count = $urandom_range(1, 6);
        repeat (count) begin
          case ($urandom_range(0, 3))
            0: append_text(" ");
            1: append_text($urandom_range(0, 1) ? "-" : "+");
            2: append_text($sformatf("%0d", $urandom_range(0, 9)));
            default: text_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      send_text();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("decimal_text_to_int32_saturating_tb: done, clean");
    end else begin
      $display("decimal_text_to_int32_saturating_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("decimal_text_to_int32_saturating_tb: done, errors");
    $finish;
  end

endmodule
